// ===== src/fr_pkg.sv =====
// shared constants for the fraction reducer
package fr_pkg;

  localparam int VALUE_BITS = 31;
  localparam int DATA_BITS  = ((2 * VALUE_BITS + 7) / 8) * 8;
  localparam int COUNT_BITS = $clog2(VALUE_BITS);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [COUNT_BITS-1:0] count_t;

endpackage

// ===== src/fraction_reducer.sv =====
// fraction_reducer: reduces a fraction to lowest terms, one word at a time.
// A word is taken only while the block is idle. The binary gcd unit finds the
// gcd of the two terms, then the shared restoring divider divides numerator
// and denominator by the gcd at one bit per cycle. A word with a zero
// numerator or denominator passes through unchanged. The result sits in an
// output register, and the next word may be accepted while it waits.
module fraction_reducer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // numerator_in [30:0], denominator_in [61:31], zero fill above
  input  logic [fr_pkg::DATA_BITS-1:0] s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // numerator_out [30:0], denominator_out [61:31], zero fill above
  output logic [fr_pkg::DATA_BITS-1:0] m_tdata
);

  localparam int W = fr_pkg::VALUE_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_GCD  = 3'd1;
  localparam logic [2:0] ST_DIVN = 3'd2;
  localparam logic [2:0] ST_DIVD = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]     state;
  fr_pkg::value_t num_in;
  fr_pkg::value_t den_in;
  fr_pkg::value_t den_hold;
  fr_pkg::value_t num_hold;
  fr_pkg::value_t res_num;
  fr_pkg::value_t res_den;
  logic           accept;
  logic           has_zero;
  logic           gcd_start;
  logic           gcd_done;
  fr_pkg::value_t gcd_value;
  logic           div_start;
  logic           div_done;
  fr_pkg::value_t div_dividend;
  fr_pkg::value_t div_quotient;
  logic           out_free;

  assign num_in   = s_tdata[W-1:0];
  assign den_in   = s_tdata[2*W-1:W];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign has_zero = (num_in == '0) || (den_in == '0);
  assign out_free = !m_tvalid || m_tready;

  assign gcd_start    = accept && !has_zero;
  assign div_start    = ((state == ST_GCD) && gcd_done) || ((state == ST_DIVN) && div_done);
  assign div_dividend = (state == ST_GCD) ? num_hold : den_hold;

  fr_gcd u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (gcd_start),
    .a_in  (num_in),
    .b_in  (den_in),
    .done  (gcd_done),
    .gcd   (gcd_value)
  );

  fr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (gcd_value),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            num_hold <= num_in;
            den_hold <= den_in;
            res_num  <= num_in;
            res_den  <= den_in;
            state    <= has_zero ? ST_DONE : ST_GCD;
          end
        end
        ST_GCD: begin
          if (gcd_done) begin
            state <= ST_DIVN;
          end
        end
        ST_DIVN: begin
          if (div_done) begin
            res_num <= div_quotient;
            state   <= ST_DIVD;
          end
        end
        ST_DIVD: begin
          if (div_done) begin
            res_den <= div_quotient;
            state   <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold here until the output register is free
          if (out_free) begin
            m_tdata  <= {{(fr_pkg::DATA_BITS - 2 * W){1'b0}}, res_den, res_num};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input taken while a word is in progress");

  a_zero_bypass: assert property (@(posedge clk) disable iff (rst)
    accept && has_zero |=> state == ST_DONE && res_num == $past(num_in))
    else $error("zero operand word not passed through");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_DONE)
    else $error("result shown without finishing the word");

  a_gcd_in_gcd_state: assert property (@(posedge clk) disable iff (rst)
    gcd_done |-> state == ST_GCD)
    else $error("gcd finished outside its phase");

endmodule

// ===== src/fr_gcd.sv =====
// binary gcd unit: one subtract or shift step per cycle
module fr_gcd (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  fr_pkg::value_t  a_in,
  input  fr_pkg::value_t  b_in,
  output logic            done,
  output fr_pkg::value_t  gcd
);

  logic           busy;
  fr_pkg::value_t a;
  fr_pkg::value_t b;
  fr_pkg::count_t k;
  logic           a_ge_b;
  fr_pkg::value_t big;
  fr_pkg::value_t little;
  fr_pkg::value_t diff;

  assign a_ge_b = (a >= b);
  assign big    = a_ge_b ? a : b;
  assign little = a_ge_b ? b : a;
  assign diff   = big - little;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        a    <= a_in;
        b    <= b_in;
        k    <= '0;
      end else if (busy) begin
        if (a == b) begin
          busy <= 1'b0;
          done <= 1'b1;
          gcd  <= a << k;
        end else if (!a[0] && !b[0]) begin
          // common factor of two, restored at the end
          a <= a >> 1;
          b <= b >> 1;
          k <= k + fr_pkg::count_t'(1);
        end else if (!a[0]) begin
          a <= a >> 1;
        end else if (!b[0]) begin
          b <= b >> 1;
        end else if (a_ge_b) begin
          // both odd, so the difference is even
          a <= diff >> 1;
        end else begin
          b <= diff >> 1;
        end
      end
    end
  end

endmodule

// ===== src/fr_div.sv =====
// restoring divider: one quotient bit per cycle
module fr_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  fr_pkg::value_t  dividend,
  input  fr_pkg::value_t  divisor,
  output logic            done,
  output fr_pkg::value_t  quotient
);

  localparam int W = fr_pkg::VALUE_BITS;

  logic           busy;
  fr_pkg::count_t cnt;
  fr_pkg::value_t rem;
  fr_pkg::value_t dvs;
  logic [W:0]     shifted;
  logic [W:0]     trial;

  assign shifted = {rem, quotient[W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= fr_pkg::count_t'(W - 1);
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        // quotient register shifts the dividend out and the result in
        if (!trial[W]) begin
          rem      <= trial[W-1:0];
          quotient <= {quotient[W-2:0], 1'b1};
        end else begin
          rem      <= shifted[W-1:0];
          quotient <= {quotient[W-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - fr_pkg::count_t'(1);
        end
      end
    end
  end

endmodule

// ===== dv/fr_checker.sv =====
// checker for the fraction reducer: predicts lowest terms and compares result words
module fr_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  // numerator_in [30:0], denominator_in [61:31], zero fill above
  input  logic [fr_pkg::DATA_BITS-1:0] s_tdata,
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  // numerator_out [30:0], denominator_out [61:31], zero fill above
  input  logic [fr_pkg::DATA_BITS-1:0] m_tdata,
  output int                           failures,
  output int                           pending
);

  // numerator sits in the low bits, as on the bus
  typedef struct packed {
    fr_pkg::value_t den;
    fr_pkg::value_t num;
  } fraction_t;

  fraction_t expected_fractions[$];

  // divide both terms by their gcd; a zero term leaves the pair as it is
  function automatic fraction_t lowest_terms(input fraction_t f);
    longint unsigned a;
    longint unsigned b;
    longint unsigned r;
    fraction_t reduced;
    reduced = f;
    if (f.num != '0 && f.den != '0) begin
      a = 64'(f.num);
      b = 64'(f.den);
      while (b != 0) begin
        r = a % b;
        a = b;
        b = r;
      end
      reduced.num = fr_pkg::value_t'(f.num / a);
      reduced.den = fr_pkg::value_t'(f.den / a);
    end
    return reduced;
  endfunction

  always @(posedge clk) begin : watch
    fraction_t got;
    fraction_t want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        expected_fractions = {expected_fractions,
          lowest_terms(fraction_t'(s_tdata[2*fr_pkg::VALUE_BITS-1:0]))};
      if (m_tvalid && m_tready) begin
        got = fraction_t'(m_tdata[2*fr_pkg::VALUE_BITS-1:0]);
        if (expected_fractions.size() == 0) begin
          $error("unexpected result word: numerator_out %0d, denominator_out %0d",
                 got.num, got.den);
          failures = failures + 1;
        end else begin
          want = expected_fractions.pop_front();
          if (got.num !== want.num) begin
            $error("numerator_out mismatch: expected %0d, actual %0d", want.num, got.num);
            failures = failures + 1;
          end
          if (got.den !== want.den) begin
            $error("denominator_out mismatch: expected %0d, actual %0d", want.den, got.den);
            failures = failures + 1;
          end
        end
      end
      pending = expected_fractions.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
// testbench top for the fraction reducer: stimulus, stalls, watchdog and verdict
module tb;

  localparam int             STALL_LIMIT = 2000;
  localparam int             DRAIN_CYCLES = 200;
  localparam int             RANDOM_ITEMS = 630;
  localparam fr_pkg::value_t TOP_VALUE = '1;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [fr_pkg::DATA_BITS-1:0] s_tdata = '0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [fr_pkg::DATA_BITS-1:0] m_tdata;

  int failures;
  int pending;
  int idle_cycles = 0;
  bit steady = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  fraction_reducer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  fr_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .failures (failures),
    .pending  (pending)
  );

  // nonzero value of random bit length, top bit of that length set
  function automatic fr_pkg::value_t wide_value(input int max_bits);
    int             w;
    fr_pkg::value_t v;
    w = $urandom_range(1, max_bits);
    v = fr_pkg::value_t'($urandom) & (TOP_VALUE >> (fr_pkg::VALUE_BITS - w));
    v[w-1] = 1'b1;
    return v;
  endfunction

  function automatic fr_pkg::value_t fib_value(input int k);
    fr_pkg::value_t a;
    fr_pkg::value_t b;
    fr_pkg::value_t t;
    a = '0;
    b = fr_pkg::value_t'(1);
    repeat (k) begin
      t = a + b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_fraction(input fr_pkg::value_t num, input fr_pkg::value_t den);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) begin
        s_tdata = {$urandom, $urandom};
        @(negedge clk);
      end
    end
    s_tdata  = {{(fr_pkg::DATA_BITS - 2*fr_pkg::VALUE_BITS){1'b0}}, den, num};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_random_fraction();
    int             pick;
    int             shift;
    fr_pkg::value_t g;
    fr_pkg::value_t num;
    fr_pkg::value_t den;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      num = wide_value(fr_pkg::VALUE_BITS);
      den = wide_value(fr_pkg::VALUE_BITS);
    end else if (pick < 60) begin
      // common factor of random size
      g   = wide_value(20);
      num = g * fr_pkg::value_t'($urandom_range(1, TOP_VALUE / g));
      den = g * fr_pkg::value_t'($urandom_range(1, TOP_VALUE / g));
    end else if (pick < 70) begin
      shift = $urandom_range(0, fr_pkg::VALUE_BITS - 1);
      num   = fr_pkg::value_t'($urandom_range(1, TOP_VALUE >> shift)) << shift;
      den   = fr_pkg::value_t'($urandom_range(1, TOP_VALUE >> shift)) << shift;
    end else if (pick < 78) begin
      num = wide_value(fr_pkg::VALUE_BITS);
      den = num;
    end else if (pick < 84) begin
      den = wide_value(16);
      num = den * fr_pkg::value_t'($urandom_range(1, TOP_VALUE / den));
      if ($urandom_range(0, 1)) begin
        g   = num;
        num = den;
        den = g;
      end
    end else if (pick < 90) begin
      num = fr_pkg::value_t'($urandom_range(1, 64));
      den = fr_pkg::value_t'($urandom_range(1, 64));
    end else if (pick < 94) begin
      // zero term passes straight through
      num = $urandom_range(0, 1) ? '0 : wide_value(fr_pkg::VALUE_BITS);
      den = (num != '0) ? '0 :
            ($urandom_range(0, 2) == 0 ? '0 : wide_value(fr_pkg::VALUE_BITS));
    end else begin
      // consecutive fibonacci numbers are the longest euclid runs
      shift = $urandom_range(1, 45);
      num   = fib_value(shift + 1);
      den   = fib_value(shift);
      if ($urandom_range(0, 1)) begin
        g   = num;
        num = den;
        den = g;
      end
    end
    send_fraction(num, den);
  endtask

  initial begin : result_sink
    int stall;
    wait (!rst);
    forever begin
      @(negedge clk);
      stall = steady ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_fraction(fr_pkg::value_t'(1), fr_pkg::value_t'(1));
    send_fraction(TOP_VALUE, TOP_VALUE);
    send_fraction(TOP_VALUE, fr_pkg::value_t'(1));
    send_fraction(fr_pkg::value_t'(1), TOP_VALUE);
    send_fraction('0, fr_pkg::value_t'(5));
    send_fraction(fr_pkg::value_t'(12), '0);
    send_fraction('0, '0);
    send_fraction('0, TOP_VALUE);
    send_fraction(TOP_VALUE, '0);
    send_fraction(fr_pkg::value_t'(6), fr_pkg::value_t'(4));
    send_fraction(TOP_VALUE - fr_pkg::value_t'(1), TOP_VALUE >> 1);
    send_fraction(fr_pkg::value_t'(1) << 30, fr_pkg::value_t'(1) << 20);
    send_fraction(fr_pkg::value_t'(3) << 28, fr_pkg::value_t'(5) << 28);
    send_fraction(fr_pkg::value_t'(1836311903), fr_pkg::value_t'(1134903170));
    send_fraction(fr_pkg::value_t'(1134903170), fr_pkg::value_t'(1836311903));
    send_fraction(31'h2AAAAAAA, 31'h55555555);
    send_fraction(31'h55555555, 31'h2AAAAAAA);
    send_fraction(TOP_VALUE, TOP_VALUE - fr_pkg::value_t'(1));
    send_fraction(fr_pkg::value_t'(1) << 30, fr_pkg::value_t'(1) << 30);
    send_fraction(fr_pkg::value_t'(2), fr_pkg::value_t'(1));
    send_fraction(fr_pkg::value_t'(1), fr_pkg::value_t'(2));
    send_fraction(fr_pkg::value_t'(1) << 30, fr_pkg::value_t'(3));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // every hundred words, a stretch of twenty without stalls
      steady = (i % 100) >= 80;
      send_random_fraction();
    end
    steady   = 1'b0;
    s_tvalid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (failures == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
